/* rtl/lsc_pkg.sv */
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and constants shared by the LCD serial command shifter.
// ----------------------------------------------------------------------------
package lsc_pkg;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_GAP    = 3'd1,
        PH_DRIVE  = 3'd2,
        PH_HOLD   = 3'd3,
        PH_SAMPLE = 3'd4,
        PH_SHOLD  = 3'd5
    } t_phase;

    localparam logic [2:0] OP_IDLE = 3'd0;
    localparam logic [2:0] OP_CMD  = 3'd1;
    localparam logic [2:0] OP_DATA = 3'd2;
    localparam logic [2:0] OP_RAW  = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    localparam logic [1:0] CFG_CLOCK_PULSE_HIGH   = 2'd0;
    localparam logic [1:0] CFG_SELECT_ACTIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_NINE_BIT_MODE      = 2'd2;
    localparam logic [1:0] CFG_SEPARATE_MISO      = 2'd3;

    localparam logic [7:0] PFX_CMD_HIGH = 8'h20;
    localparam logic [7:0] PFX_CMD_LOW  = 8'h00;
    localparam logic [7:0] PFX_DATA     = 8'h40;

    localparam logic [4:0] BITS_WORD  = 5'd16;
    localparam logic [4:0] BITS_NINE  = 5'd9;
    localparam logic [4:0] BITS_BYTE  = 5'd8;

endpackage

/* rtl/lcd_serial_command_shifter.sv */
// ----------------------------------------------------------------------------
// lcd_serial_command_shifter
// Tick-level 3-wire serial shifter for LCD register, data and read requests.
// ----------------------------------------------------------------------------
// Usage:
//   Every input item is one tick of the serial interface. An item with a
//   request op starts a command, data, raw or read transfer when the shifter
//   is idle; requests while busy are ignored. Every accepted item yields
//   exactly one result item holding the pin levels (sck, mosi, cs,
//   sda_drive), busy flag, read byte and read-done pulse for that tick.
//   Input channel: i_valid / o_stall. Output channel: o_valid / i_stall.
//   The result of an accepted item is registered and is on the outputs in
//   the cycle after it is accepted. One item per cycle is sustained while
//   the receiver does not stall; the single result register is refilled
//   in the cycle it is taken. When the receiver stalls with a result held,
//   o_stall rises and the shifter state holds until the result is taken.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) are registered
//   directly and are meant for idle periods.
//   Synchronous active-low reset: idle phase, counters and shift registers
//   cleared, configuration at its defaults, no result pending.
// ----------------------------------------------------------------------------
module lcd_serial_command_shifter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_value,
    input  logic        i_dc_bit,
    input  logic        i_sda_in,
    input  logic        i_miso_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_sck,
    output logic        o_mosi,
    output logic        o_cs,
    output logic        o_sda_drive,
    output logic        o_busy_res,
    output logic [7:0]  o_read_data,
    output logic        o_read_done,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic        i_cfg_data
);

    logic r_clock_pulse_high;
    logic r_select_active_high;
    logic r_nine_bit_mode;
    logic r_separate_miso;

    lsc_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_shift_word, n_shift_word;
    logic [15:0] r_pending_word, n_pending_word;
    logic [4:0]  r_bits_left, n_bits_left;
    logic [2:0]  r_job_kind, n_job_kind;
    logic [7:0]  r_read_shift, n_read_shift;

    logic r_valid;
    logic r_sck, r_mosi, r_cs, r_sda_drive, r_busy, r_done;
    logic n_sck, n_mosi, n_cs, n_sda_drive, n_busy, n_done;

    logic w_accept;
    logic w_cur_bit;
    logic w_sample_bit;
    logic [4:0] w_bit_idx;

    assign o_stall  = r_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign w_bit_idx = r_bits_left - 5'd1;
    assign w_cur_bit = (r_bits_left != 5'd0 && r_bits_left <= lsc_pkg::BITS_WORD)
                       ? r_shift_word[w_bit_idx[3:0]] : 1'b0;
    assign w_sample_bit = r_separate_miso ? i_miso_in : i_sda_in;

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_shift_word   = r_shift_word;
        n_pending_word = r_pending_word;
        n_bits_left    = r_bits_left;
        n_job_kind     = r_job_kind;
        n_read_shift   = r_read_shift;
        n_busy         = 1'b1;
        n_done         = 1'b0;
        unique case (r_phase)
            lsc_pkg::PH_IDLE: begin
                case (i_op) inside
                    lsc_pkg::OP_CMD, lsc_pkg::OP_DATA,
                    lsc_pkg::OP_RAW, lsc_pkg::OP_READ: begin
                        n_job_kind = i_op;
                        n_phase    = lsc_pkg::PH_DRIVE;
                        if (i_op == lsc_pkg::OP_CMD) begin
                            n_shift_word   = {lsc_pkg::PFX_CMD_HIGH, i_value[15:8]};
                            n_pending_word = {lsc_pkg::PFX_CMD_LOW, i_value[7:0]};
                            n_bits_left    = lsc_pkg::BITS_WORD;
                        end else if (i_op == lsc_pkg::OP_DATA) begin
                            n_shift_word = {lsc_pkg::PFX_DATA, i_value[7:0]};
                            n_bits_left  = lsc_pkg::BITS_WORD;
                        end else if (r_nine_bit_mode) begin
                            n_shift_word = {7'd0, i_dc_bit, i_value[7:0]};
                            n_bits_left  = lsc_pkg::BITS_NINE;
                        end else begin
                            n_shift_word = {8'd0, i_value[7:0]};
                            n_bits_left  = lsc_pkg::BITS_BYTE;
                        end
                    end
                    default: begin
                        n_busy = 1'b0;
                    end
                endcase
            end
            lsc_pkg::PH_GAP: begin
                n_phase = lsc_pkg::PH_DRIVE;
            end
            lsc_pkg::PH_DRIVE: begin
                n_phase = lsc_pkg::PH_HOLD;
            end
            lsc_pkg::PH_HOLD: begin
                if (r_bits_left > 5'd1 && r_bits_left <= lsc_pkg::BITS_WORD) begin
                    n_bits_left = r_bits_left - 5'd1;
                    n_phase     = lsc_pkg::PH_DRIVE;
                end else begin
                    n_bits_left = 5'd0;
                    if (r_job_kind == lsc_pkg::OP_CMD) begin
                        n_shift_word = r_pending_word;
                        n_bits_left  = lsc_pkg::BITS_WORD;
                        n_job_kind   = lsc_pkg::OP_DATA;
                        n_phase      = lsc_pkg::PH_GAP;
                    end else if (r_job_kind == lsc_pkg::OP_READ) begin
                        n_bits_left = lsc_pkg::BITS_BYTE;
                        n_phase     = lsc_pkg::PH_SAMPLE;
                    end else begin
                        n_phase = lsc_pkg::PH_IDLE;
                    end
                end
            end
            lsc_pkg::PH_SAMPLE: begin
                n_read_shift = {r_read_shift[6:0], w_sample_bit};
                n_phase      = lsc_pkg::PH_SHOLD;
            end
            lsc_pkg::PH_SHOLD: begin
                if (r_bits_left > 5'd1 && r_bits_left <= lsc_pkg::BITS_BYTE) begin
                    n_bits_left = r_bits_left - 5'd1;
                    n_phase     = lsc_pkg::PH_SAMPLE;
                end else begin
                    n_bits_left = 5'd0;
                    n_done      = 1'b1;
                    n_phase     = lsc_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase     = lsc_pkg::PH_IDLE;
                n_bits_left = 5'd0;
                n_busy      = 1'b0;
            end
        endcase
    end

    // pin levels for this tick
    always_comb begin
        n_sck       = ~r_clock_pulse_high;
        n_mosi      = 1'b0;
        n_cs        = ~r_select_active_high;
        n_sda_drive = 1'b1;
        unique case (r_phase)
            lsc_pkg::PH_DRIVE: begin
                n_cs   = r_select_active_high;
                n_sck  = r_clock_pulse_high;
                n_mosi = w_cur_bit;
            end
            lsc_pkg::PH_HOLD: begin
                n_cs   = r_select_active_high;
                n_mosi = w_cur_bit;
            end
            lsc_pkg::PH_SAMPLE: begin
                n_cs        = r_select_active_high;
                n_sck       = r_clock_pulse_high;
                n_sda_drive = r_separate_miso;
            end
            lsc_pkg::PH_SHOLD: begin
                n_cs        = r_select_active_high;
                n_sda_drive = r_separate_miso;
            end
            default: begin
                n_sck = ~r_clock_pulse_high;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_pulse_high   <= 1'b1;
            r_select_active_high <= 1'b0;
            r_nine_bit_mode      <= 1'b1;
            r_separate_miso      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsc_pkg::CFG_CLOCK_PULSE_HIGH:   r_clock_pulse_high   <= i_cfg_data;
                lsc_pkg::CFG_SELECT_ACTIVE_HIGH: r_select_active_high <= i_cfg_data;
                lsc_pkg::CFG_NINE_BIT_MODE:      r_nine_bit_mode      <= i_cfg_data;
                lsc_pkg::CFG_SEPARATE_MISO:      r_separate_miso      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= lsc_pkg::PH_IDLE;
            r_shift_word   <= 16'd0;
            r_pending_word <= 16'd0;
            r_bits_left    <= 5'd0;
            r_job_kind     <= lsc_pkg::OP_IDLE;
            r_read_shift   <= 8'd0;
            r_valid        <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_valid <= i_valid;
            end
            if (w_accept) begin
                r_phase        <= n_phase;
                r_shift_word   <= n_shift_word;
                r_pending_word <= n_pending_word;
                r_bits_left    <= n_bits_left;
                r_job_kind     <= n_job_kind;
                r_read_shift   <= n_read_shift;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sck       <= n_sck;
            r_mosi      <= n_mosi;
            r_cs        <= n_cs;
            r_sda_drive <= n_sda_drive;
            r_busy      <= n_busy;
            r_done      <= n_done;
        end
    end

    assign o_valid     = r_valid;
    assign o_sck       = r_sck;
    assign o_mosi      = r_mosi;
    assign o_cs        = r_cs;
    assign o_sda_drive = r_sda_drive;
    assign o_busy_res  = r_busy;
    assign o_read_data = r_read_shift;
    assign o_read_done = r_done;

endmodule
